// ----- hdl/cact_pkg.sv -----
// Shared types and constants for the call-arc counting table.
`default_nettype none

package cact_pkg;

	// Table depth default and word widths.
	localparam int ARC_ENTRIES_DEF = 64;
	localparam int ADDR_W          = 32;
	localparam int KEY_W           = 2 * ADDR_W;
	localparam int COUNT_W         = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes carried in the func field.
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_DUMP   = 1'b1;

	// Request word.
	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] caller_addr;
		logic [ADDR_W-1:0] callee_addr;
	} req_t;

	// Response word.
	typedef struct packed {
		logic [ADDR_W-1:0]  arc_caller;
		logic [ADDR_W-1:0]  arc_callee;
		logic [COUNT_W-1:0] arc_count;
		logic               table_empty;
		logic               arcs_dropped;
		logic               last_arc;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic key_load;
		logic idx_clr;
		logic idx_inc;
		logic idx_dec;
		logic idx_load_used;
		logic pos_save;
		logic rd_prev;
		logic wr_bump;
		logic wr_shift;
		logic wr_insert;
		logic used_inc;
		logic ovf_set;
		logic out_load_arc;
		logic out_load_empty;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_eq_used;
		logic idx_eq_pos;
		logic idx_last;
		logic key_lt;
		logic key_eq;
		logic full;
		logic empty;
		logic slot_free;
	} ctl_status_t;

endpackage

`default_nettype wire

// ----- hdl/cact_datapath.sv -----
// Datapath of the call-arc counting table: arc memories, counters and response register.
`default_nettype none

module cact_datapath import cact_pkg::*; #(
	parameter int ARC_ENTRIES = ARC_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire req_t        req,
	input  wire ctl_cmd_t    cmd,
	output      ctl_status_t status,
	output      logic        rsp_valid,
	input  wire logic        rsp_ready,
	output      rsp_t        rsp
);

	localparam int AW = (ARC_ENTRIES > 1) ? $clog2(ARC_ENTRIES) : 1;
	localparam int IW = $clog2(ARC_ENTRIES + 1);
	localparam logic [IW-1:0] FULL_COUNT = IW'(ARC_ENTRIES);

	// Sorted arc storage.
	logic [KEY_W-1:0]   key_mem [ARC_ENTRIES];
	logic [COUNT_W-1:0] cnt_mem [ARC_ENTRIES];

	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      used_q;
	logic               ovf_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   rd_key_q;
	logic [COUNT_W-1:0] rd_cnt_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [IW-1:0]      idx_prev;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [COUNT_W-1:0] cnt_bumped;
	logic [COUNT_W-1:0] cnt_wdata;
	logic [KEY_W-1:0]   key_wdata;

	// Read and write addresses.
	assign idx_prev = idx_q - IW'(1);
	assign rd_addr  = cmd.rd_prev ? idx_prev[AW-1:0] : idx_q[AW-1:0];
	assign wr_addr  = cmd.wr_insert ? pos_q[AW-1:0] : idx_q[AW-1:0];

	// Saturating count increment.
	assign cnt_bumped = (rd_cnt_q == COUNT_MAX) ? COUNT_MAX : rd_cnt_q + COUNT_W'(1);

	// Write data: a new arc starts at one, a bump counts up, a moved arc is copied.
	always_comb begin
		key_wdata = rd_key_q;
		cnt_wdata = rd_cnt_q;
		if (cmd.wr_insert) begin
			key_wdata = key_q;
			cnt_wdata = COUNT_W'(1);
		end else if (cmd.wr_bump) begin
			cnt_wdata = cnt_bumped;
		end
	end

	// Memories with registered read data.
	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_insert) begin
			key_mem[wr_addr] <= key_wdata;
		end
		if (cmd.wr_shift || cmd.wr_insert || cmd.wr_bump) begin
			cnt_mem[wr_addr] <= cnt_wdata;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_cnt_q <= cnt_mem[rd_addr];
	end

	// Control counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			used_q      <= '0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_prev;
			end else if (cmd.idx_load_used) begin
				idx_q <= used_q;
			end
			if (cmd.used_inc) begin
				used_q <= used_q + IW'(1);
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.out_load_arc || cmd.out_load_empty) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Search key, insert position and response payload.
	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= {req.callee_addr, req.caller_addr};
		end
		if (cmd.pos_save) begin
			pos_q <= idx_q;
		end
		if (cmd.out_load_arc) begin
			rsp_q.arc_caller   <= rd_key_q[ADDR_W-1:0];
			rsp_q.arc_callee   <= rd_key_q[KEY_W-1:ADDR_W];
			rsp_q.arc_count    <= rd_cnt_q;
			rsp_q.table_empty  <= 1'b0;
			rsp_q.arcs_dropped <= ovf_q;
			rsp_q.last_arc     <= status.idx_last;
		end else if (cmd.out_load_empty) begin
			rsp_q.arc_caller   <= '0;
			rsp_q.arc_callee   <= '0;
			rsp_q.arc_count    <= '0;
			rsp_q.table_empty  <= 1'b1;
			rsp_q.arcs_dropped <= ovf_q;
			rsp_q.last_arc     <= 1'b1;
		end
	end

	// Status back to the controller.
	assign status.idx_eq_used = (idx_q == used_q);
	assign status.idx_eq_pos  = (idx_q == pos_q);
	assign status.idx_last    = ((idx_q + IW'(1)) == used_q);
	assign status.key_lt      = (rd_key_q < key_q);
	assign status.key_eq      = (rd_key_q == key_q);
	assign status.full        = (used_q == FULL_COUNT);
	assign status.empty       = (used_q == '0);
	assign status.slot_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- hdl/cact_ctrl.sv -----
// Controller state machine of the call-arc counting table.
`default_nettype none

module cact_ctrl import cact_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_ready,
	input  wire logic        func,
	input  wire ctl_status_t status,
	output      ctl_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SCAN_RD   = 4'd1;
	localparam logic [3:0] ST_SCAN_CMP  = 4'd2;
	localparam logic [3:0] ST_SHIFT_CHK = 4'd3;
	localparam logic [3:0] ST_SHIFT_RD  = 4'd4;
	localparam logic [3:0] ST_SHIFT_WR  = 4'd5;
	localparam logic [3:0] ST_INSERT    = 4'd6;
	localparam logic [3:0] ST_DUMP_RD   = 4'd7;
	localparam logic [3:0] ST_DUMP_LD   = 4'd8;
	localparam logic [3:0] ST_EMPTY     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign req_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.key_load = 1'b1;
					cmd.idx_clr  = 1'b1;
					if (func == FUNC_RECORD) begin
						state_nxt = ST_SCAN_RD;
					end else if (status.empty) begin
						state_nxt = ST_EMPTY;
					end else begin
						state_nxt = ST_DUMP_RD;
					end
				end
			end
			// Walk the sorted table until a key not below the new one or the end of the stored arcs.
			ST_SCAN_RD: begin
				if (status.idx_eq_used) begin
					if (status.full) begin
						cmd.ovf_set = 1'b1;
						state_nxt   = ST_IDLE;
					end else begin
						cmd.pos_save = 1'b1;
						state_nxt    = ST_SHIFT_CHK;
					end
				end else begin
					state_nxt = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (status.key_lt) begin
					cmd.idx_inc = 1'b1;
					state_nxt   = ST_SCAN_RD;
				end else if (status.key_eq) begin
					cmd.wr_bump = 1'b1;
					state_nxt   = ST_IDLE;
				end else if (status.full) begin
					cmd.ovf_set = 1'b1;
					state_nxt   = ST_IDLE;
				end else begin
					// Remember the slot, then move the upper arcs up from the end.
					cmd.pos_save      = 1'b1;
					cmd.idx_load_used = 1'b1;
					state_nxt         = ST_SHIFT_CHK;
				end
			end
			ST_SHIFT_CHK: begin
				if (status.idx_eq_pos) begin
					state_nxt = ST_INSERT;
				end else begin
					cmd.rd_prev = 1'b1;
					state_nxt   = ST_SHIFT_RD;
				end
			end
			ST_SHIFT_RD: begin
				cmd.rd_prev = 1'b1;
				state_nxt   = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec  = 1'b1;
				state_nxt    = ST_SHIFT_CHK;
			end
			ST_INSERT: begin
				cmd.wr_insert = 1'b1;
				cmd.used_inc  = 1'b1;
				state_nxt     = ST_IDLE;
			end
			// Dump: one arc per read, held until the response slot frees up.
			ST_DUMP_RD: begin
				state_nxt = ST_DUMP_LD;
			end
			ST_DUMP_LD: begin
				if (status.slot_free) begin
					cmd.out_load_arc = 1'b1;
					cmd.idx_inc      = 1'b1;
					state_nxt        = status.idx_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			ST_EMPTY: begin
				if (status.slot_free) begin
					cmd.out_load_empty = 1'b1;
					state_nxt          = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/call_arc_counting_table_unit.sv -----
// Top level of the call-arc counting table: controller and datapath.
`default_nettype none

// Counts call arcs (caller return address, callee address) in a table of up
// to ARC_ENTRIES arcs kept sorted by the key {callee, caller}, in one pair of
// single-port-read memories. A record word scans the table from the bottom,
// reading and comparing each stored arc below the new key; a known arc has
// its count bumped (saturating), a new arc moves every arc above it up by one
// slot, starting from the top, and is then written.
// A new arc that finds the table full is dropped and sets the sticky
// arcs_dropped flag. A dump word emits every stored arc in ascending key
// order, each one held until the response slot is free, with last_arc
// on the final word, or a single word with table_empty set if no arcs are
// stored. The request side takes a new word only when the previous one is
// finished; the response register lets a new request in while the last
// response word still waits to be taken.
module call_arc_counting_table_unit import cact_pkg::*; #(
	parameter int ARC_ENTRIES = ARC_ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_ready,
	input  wire req_t req,
	output      logic rsp_valid,
	input  wire logic rsp_ready,
	output      rsp_t rsp
);

	ctl_cmd_t    cmd;
	ctl_status_t status;

	cact_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (req.func),
		.status    (status),
		.cmd       (cmd)
	);

	cact_datapath #(
		.ARC_ENTRIES (ARC_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// The table is never written while a new request word can be taken.
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !(cmd.wr_bump || cmd.wr_shift || cmd.wr_insert))
		else $error("table write while the request side is ready");

	// A response word is only loaded into a free slot.
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load_arc || cmd.out_load_empty) |-> status.slot_free)
		else $error("response word overwritten before it was taken");

	// A new arc is never written into a full table.
	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_insert |-> !status.full)
		else $error("insert into a full table");

	// The empty-table word only goes out when no arcs are stored.
	a_empty_word_only_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load_empty |-> status.empty)
		else $error("empty-table word with arcs stored");
`endif

endmodule

`default_nettype wire
